[rtl/core/kfd_pkg.sv]
package kfd_pkg;

  // Framing bytes
  localparam logic [7:0] BYTE_FEND  = 8'hC0;
  localparam logic [7:0] BYTE_FESC  = 8'hDB;
  localparam logic [7:0] BYTE_TFEND = 8'hDC;
  localparam logic [7:0] BYTE_TFESC = 8'hDD;

  // Field widths
  localparam int unsigned POS_W = 13;
  localparam int unsigned SET_W = 12;

  // Payload bytes kept per frame
  localparam logic [POS_W-1:0] MAX_FRAME = POS_W'(512);

  // Command codes (low nibble of the first byte of a frame)
  typedef enum logic [3:0] {
    CTL_DATA     = 4'd0,
    CTL_TXDELAY  = 4'd1,
    CTL_PERSIST  = 4'd2,
    CTL_SLOTTIME = 4'd3,
    CTL_TXTAIL   = 4'd4
  } cmd_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_TXDELAY  = 3'd2,
    KIND_TXTAIL   = 3'd3,
    KIND_SLOTTIME = 3'd4,
    KIND_PERSIST  = 3'd5
  } kind_t;

  // One result item, with a flag telling whether the step produced one
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
    logic [SET_W-1:0] setting_value;
  } result_t;

  // Byte times ten as two shifted adds
  function automatic logic [SET_W-1:0] times_ten(input logic [7:0] b);
    logic [SET_W-1:0] w;
    begin
      w = SET_W'(b);
      times_ten = (w << 3) + (w << 1);
    end
  endfunction

endpackage

[rtl/core/kfd_in_reg.sv]
module kfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte
);
  import kfd_pkg::*;

  logic       valid;
  logic [7:0] held_byte;

  // Accept when empty or when the held byte moves on this cycle
  assign in_ready = !valid || take;

  // Hold the received byte until the step stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

  assign item_valid = valid;
  assign item_byte  = held_byte;

endmodule

[rtl/core/kfd_core.sv]
module kfd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       item_byte,
  output kfd_pkg::result_t res
);
  import kfd_pkg::*;

  logic             inside_frame, inside_frame_next;
  logic             escape_pending, escape_pending_next;
  logic             command_known, command_known_next;
  logic [3:0]       command_code, command_code_next;
  logic [POS_W-1:0] byte_count, byte_count_next;

  logic       is_data;
  logic       is_fend;
  logic [7:0] unesc;

  assign is_data = command_known && (command_code == CTL_DATA);
  assign is_fend = (item_byte == BYTE_FEND);

  // Translate the byte after an escape
  always_comb begin
    unesc = item_byte;
    if (escape_pending) begin
      if (item_byte == BYTE_TFEND) begin
        unesc = BYTE_FEND;
      end else if (item_byte == BYTE_TFESC) begin
        unesc = BYTE_FESC;
      end
    end
  end

  // Step the deframer for one byte
  always_comb begin
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    command_known_next  = command_known;
    command_code_next   = command_code;
    byte_count_next     = byte_count;
    res                 = '0;
    res.kind            = KIND_DATA;

    if (inside_frame && is_fend && is_data) begin
      // close the data frame, report its length
      inside_frame_next = 1'b0;
      res.valid         = 1'b1;
      res.kind          = KIND_DONE;
      res.position      = byte_count;
    end else if (is_fend) begin
      // open a frame; escape flag is left alone
      inside_frame_next  = 1'b1;
      command_known_next = 1'b0;
      byte_count_next    = '0;
    end else if (!inside_frame || byte_count >= MAX_FRAME) begin
      // drop
    end else if (byte_count == '0 && !command_known) begin
      command_known_next = 1'b1;
      command_code_next  = item_byte[3:0];
    end else if (command_known) begin
      case (command_code)
        CTL_DATA: begin
          if (item_byte == BYTE_FESC) begin
            escape_pending_next = 1'b1;
          end else begin
            escape_pending_next = 1'b0;
            byte_count_next     = byte_count + POS_W'(1);
            res.valid           = 1'b1;
            res.kind            = KIND_DATA;
            res.data_byte       = unesc;
            res.position        = byte_count;
          end
        end
        CTL_TXDELAY: begin
          res.valid         = 1'b1;
          res.kind          = KIND_TXDELAY;
          res.setting_value = times_ten(item_byte);
        end
        CTL_TXTAIL: begin
          res.valid         = 1'b1;
          res.kind          = KIND_TXTAIL;
          res.setting_value = times_ten(item_byte);
        end
        CTL_SLOTTIME: begin
          res.valid         = 1'b1;
          res.kind          = KIND_SLOTTIME;
          res.setting_value = times_ten(item_byte);
        end
        CTL_PERSIST: begin
          res.valid         = 1'b1;
          res.kind          = KIND_PERSIST;
          res.setting_value = SET_W'(item_byte);
        end
        default: begin
          // unused command, ignore
        end
      endcase
    end
  end

  // Commit state when the byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      escape_pending <= 1'b0;
      command_known  <= 1'b0;
      command_code   <= '0;
      byte_count     <= '0;
    end else if (advance) begin
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      command_known  <= command_known_next;
      command_code   <= command_code_next;
      byte_count     <= byte_count_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_FRAME)
    else $error("byte count above frame limit");

  a_done_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && res.valid && res.kind == KIND_DONE) |=> !inside_frame)
    else $error("frame still open after completion");

  a_data_advances_count: assert property (@(posedge clk) disable iff (rst)
    (advance && res.valid && res.kind == KIND_DATA)
      |=> byte_count == $past(byte_count) + POS_W'(1))
    else $error("byte count did not advance on data byte");

  a_no_result_outside: assert property (@(posedge clk) disable iff (rst)
    (!inside_frame && res.valid) |-> 1'b0)
    else $error("result produced outside a frame");

endmodule

[rtl/core/kfd_out_reg.sv]
module kfd_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  kfd_pkg::result_t        res,
  output logic                    open,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              kind,
  output logic [7:0]              data_byte,
  output logic [kfd_pkg::POS_W-1:0] position,
  output logic [kfd_pkg::SET_W-1:0] setting_value
);
  import kfd_pkg::*;

  logic    valid;
  result_t held;

  // Room for a new result when empty or being drained now
  assign open = !valid || out_ready;

  // Load a result or drop the flag once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= res.valid;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      held <= res;
    end
  end

  assign out_valid     = valid;
  assign kind          = held.kind;
  assign data_byte     = held.data_byte;
  assign position      = held.position;
  assign setting_value = held.setting_value;

  a_load_only_open: assert property (@(posedge clk) disable iff (rst)
    load |-> open)
    else $error("result loaded over an untaken result");

  a_setting_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (valid && held.kind != KIND_DATA && held.kind != KIND_DONE)
      |-> (held.data_byte == 8'h00 && held.position == '0))
    else $error("setting result carries byte or position");

  a_persist_raw: assert property (@(posedge clk) disable iff (rst)
    (valid && held.kind == KIND_PERSIST) |-> held.setting_value[SET_W-1:8] == '0)
    else $error("persistence value wider than a byte");

endmodule

[rtl/core/kiss_frame_deframer.sv]
// KISS deframer: takes one host-link byte per transaction and returns at most one
// result per byte: an unescaped data byte with its index, a data-frame-complete
// record with the length, or a TX delay / TX tail / slot time value (byte times
// ten) or a raw persistence value. Each byte passes through an input register, a
// single combinational step against the frame state, and a result register, so
// the block sustains one byte per clock while out_ready is high; out_valid rises
// once an accepted byte has moved from the input register to the result register,
// and bytes that produce no result still occupy the step. While a result waits
// with out_ready low, the input register takes one more byte and in_ready then
// stays low until the result is taken. Payload beyond 512 bytes is dropped.
module kiss_frame_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                kind,
  output logic [7:0]                data_byte,
  output logic [kfd_pkg::POS_W-1:0] position,
  output logic [kfd_pkg::SET_W-1:0] setting_value
);
  import kfd_pkg::*;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       open;
  logic       advance;
  result_t    res;

  // Move the held byte through the step when the result side has room
  assign advance = item_valid && open;

  kfd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  kfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item_byte (item_byte),
    .res       (res)
  );

  kfd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .res           (res),
    .open          (open),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .position      (position),
    .setting_value (setting_value)
  );

endmodule
